FILE: rtl/core/lfsa_pkg.sv
// ----------------------------------------------------------------------------
// lfsa_pkg
// Shared widths, reset values and codes of the lowest free slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsa_pkg;

   localparam int SLOTS_DEF      = 128;
   localparam int REQUESTERS_DEF = 1024;
   localparam int WAIT_DEPTH_DEF = 256;

   localparam int ID_W     = 11;
   localparam int SLOT_W   = 8;
   localparam int RATE_W   = 16;
   localparam int WEIGHT_W = 16;
   localparam int COUNT_W  = 9;
   localparam int TOTAL_W  = 48;
   localparam int PROD_W   = RATE_W + WEIGHT_W;
   localparam int ACTIVE_W = 8;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 8'd128;
   localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = {TOTAL_W{1'b1}};

   typedef enum logic [1:0] {
      OP_LOAD_RATE = 2'd0,
      OP_ARRIVE    = 2'd1,
      OP_DEPART    = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_NO_SLOT = 2'd2
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/core/lowest_free_slot_allocator_fifo_top.sv
// A transaction is registered in stage A, then passes stages B, C and D to the output register;
// a stalled output holds every stage behind it. A new transaction enters stage B only once the
// last has left it, set by the read-then-write pass over the requester map and FIFO memories,
// and not while a hand-over makes its second write on the single map write port.
// Reset and clear-all start a clearing pass over max(REQUESTERS, SLOTS) entries (1024 by default)
// over the map (and, after reset, the rate memory); no transaction enters processing meanwhile.
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator_fifo_top
// Slot allocator: lowest free slot per arrival, waiting FIFO, saturating charge total.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_free_slot_allocator_fifo_top #(
   parameter int SLOTS      = lfsa_pkg::SLOTS_DEF,
   parameter int REQUESTERS = lfsa_pkg::REQUESTERS_DEF,
   parameter int WAIT_DEPTH = lfsa_pkg::WAIT_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_opcode,
   input  logic [lfsa_pkg::SLOT_W-1:0]     req_slot_index,
   input  logic [lfsa_pkg::RATE_W-1:0]     req_rate_value,
   input  logic [lfsa_pkg::ID_W-1:0]       req_requester_id,
   input  logic [lfsa_pkg::WEIGHT_W-1:0]   req_requester_weight,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [lfsa_pkg::ID_W-1:0]       rsp_placed_requester,
   output logic [lfsa_pkg::SLOT_W-1:0]     rsp_placed_slot,
   output logic                            rsp_was_queued,
   output logic [lfsa_pkg::COUNT_W-1:0]    rsp_waiting_count,
   output logic [lfsa_pkg::TOTAL_W-1:0]    rsp_charge_total,
   output logic [1:0]                      rsp_status,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lfsa_pkg::ACTIVE_W-1:0]   csr_active_slots
);

   localparam int SW    = $clog2(SLOTS + 1);
   localparam int SIW   = $clog2(SLOTS);
   localparam int MAW   = $clog2(REQUESTERS);
   localparam int RQW   = $clog2(REQUESTERS + 1);
   localparam int RW    = (RQW > lfsa_pkg::ID_W) ? RQW : lfsa_pkg::ID_W;
   localparam int FAW   = $clog2(WAIT_DEPTH);
   localparam int CW    = $clog2(WAIT_DEPTH + 1);
   localparam int NGRP  = (SLOTS + 7) / 8;
   localparam int LW    = (SW > lfsa_pkg::ACTIVE_W) ? SW : lfsa_pkg::ACTIVE_W;
   localparam int FW    = lfsa_pkg::ID_W + lfsa_pkg::WEIGHT_W;
   localparam int SWN   = (REQUESTERS > SLOTS) ? REQUESTERS : SLOTS;
   localparam int SCW   = $clog2(SWN);
   localparam int TW    = lfsa_pkg::TOTAL_W;

   // ---------------------------------------------------------------- memories
   logic [SW-1:0]              map_mem  [REQUESTERS];
   logic [lfsa_pkg::RATE_W-1:0] rate_mem [SLOTS];
   logic [FW-1:0]              fifo_mem [WAIT_DEPTH];

   // ---------------------------------------------------------------- state
   logic [lfsa_pkg::ACTIVE_W-1:0] active_ff;
   logic [SLOTS-1:0]              busy_ff;
   logic [FAW-1:0]                head_ff, head_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [TW-1:0]                 total_ff, total_in;

   logic                          swp_vld_ff, swp_rates_ff;
   logic [SCW-1:0]                swp_cnt_ff;
   logic                          pend_vld_ff;
   logic [MAW-1:0]                pend_addr_ff;
   logic [SW-1:0]                 pend_data_ff;

   // ---------------------------------------------------------------- stage A
   logic                           a_vld_ff;
   lfsa_pkg::op_type               a_op_ff;
   logic [lfsa_pkg::SLOT_W-1:0]    a_sidx_ff;
   logic [lfsa_pkg::RATE_W-1:0]    a_rate_ff;
   logic [lfsa_pkg::ID_W-1:0]      a_rid_ff;
   logic [lfsa_pkg::WEIGHT_W-1:0]  a_w_ff;

   // ---------------------------------------------------------------- stage B
   logic                           b_vld_ff;
   lfsa_pkg::op_type               b_op_ff;
   logic [lfsa_pkg::SLOT_W-1:0]    b_sidx_ff;
   logic [lfsa_pkg::RATE_W-1:0]    b_rate_ff;
   logic [lfsa_pkg::ID_W-1:0]      b_rid_ff;
   logic [lfsa_pkg::WEIGHT_W-1:0]  b_w_ff;
   logic [NGRP-1:0]                grp_any_ff;
   logic [2:0]                     grp_idx_ff [NGRP];
   logic [SW-1:0]                  map_rd_ff;
   logic [FW-1:0]                  fifo_rd_ff;

   // ---------------------------------------------------------------- stage C
   logic                           c_vld_ff;
   logic [lfsa_pkg::WEIGHT_W-1:0]  c_w_ff;
   logic [lfsa_pkg::RATE_W-1:0]    rate_rd_ff;
   logic                           c_clr_ff;
   logic [lfsa_pkg::ID_W-1:0]      c_req_ff;
   logic [lfsa_pkg::SLOT_W-1:0]    c_slot_ff;
   logic                           c_q_ff;
   logic [lfsa_pkg::COUNT_W-1:0]   c_cnt_ff;
   lfsa_pkg::status_type           c_st_ff;

   // ---------------------------------------------------------------- stage D
   logic                           d_vld_ff;
   logic [lfsa_pkg::PROD_W-1:0]    d_prod_ff;
   logic                           d_clr_ff;
   logic [lfsa_pkg::ID_W-1:0]      d_req_ff;
   logic [lfsa_pkg::SLOT_W-1:0]    d_slot_ff;
   logic                           d_q_ff;
   logic [lfsa_pkg::COUNT_W-1:0]   d_cnt_ff;
   lfsa_pkg::status_type           d_st_ff;

   // ---------------------------------------------------------------- output
   logic                           rsp_vld_ff;
   logic [lfsa_pkg::ID_W-1:0]      rsp_req_ff;
   logic [lfsa_pkg::SLOT_W-1:0]    rsp_slot_ff;
   logic                           rsp_q_ff;
   logic [lfsa_pkg::COUNT_W-1:0]   rsp_cnt_ff;
   logic [TW-1:0]                  rsp_tot_ff;
   lfsa_pkg::status_type           rsp_st_ff;

   logic adv;
   logic load;

   assign adv       = !rsp_vld_ff || rsp_ready;
   assign load      = a_vld_ff && !b_vld_ff && !pend_vld_ff && !swp_vld_ff;
   assign req_ready = !a_vld_ff || load;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= lfsa_pkg::ACTIVE_RESET;
      end else if (csr_valid) begin
         active_ff <= csr_active_slots;
      end
   end

   // ---------------------------------------------------------------- stage A
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         a_vld_ff <= 1'b1;
      end else if (load) begin
         a_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_op_ff   <= lfsa_pkg::op_type'(req_opcode);
         a_sidx_ff <= req_slot_index;
         a_rate_ff <= req_rate_value;
         a_rid_ff  <= req_requester_id;
         a_w_ff    <= req_requester_weight;
      end
   end

   // free slot search, first level: per group of eight
   logic [LW-1:0]         act_ext, lim;
   logic [SLOTS-1:0]      free_a;
   logic [NGRP*8-1:0]     free_pad;
   logic [NGRP-1:0]       grp_any_in;
   logic [2:0]            grp_idx_in [NGRP];
   logic [RW-1:0]         a_rid_m1;
   logic [MAW-1:0]        map_raddr;

   assign act_ext   = LW'(active_ff);
   assign lim       = (act_ext > LW'(SLOTS)) ? LW'(SLOTS) : act_ext;
   assign a_rid_m1  = RW'(a_rid_ff) - RW'(1);
   assign map_raddr = a_rid_m1[MAW-1:0];

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         free_a[i] = !busy_ff[i] && (LW'(i) < lim);
      end
   end

   assign free_pad = (NGRP*8)'(free_a);

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g] = |free_pad[g*8 +: 8];
         grp_idx_in[g] = 3'd0;
         for (int j = 7; j >= 0; j--) begin
            if (free_pad[g*8 + j]) begin
               grp_idx_in[g] = 3'(j);
            end
         end
      end
   end

   // ---------------------------------------------------------------- stage B
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (load) begin
         b_vld_ff <= 1'b1;
      end else if (adv) begin
         b_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         b_op_ff    <= a_op_ff;
         b_sidx_ff  <= a_sidx_ff;
         b_rate_ff  <= a_rate_ff;
         b_rid_ff   <= a_rid_ff;
         b_w_ff     <= a_w_ff;
         grp_any_ff <= grp_any_in;
         grp_idx_ff <= grp_idx_in;
         map_rd_ff  <= map_mem[map_raddr];
         fifo_rd_ff <= fifo_mem[head_ff];
      end
   end

   logic [SW-1:0]                 pos_b, pos_m1, mpos_m1;
   logic                          free_any;
   logic [RW-1:0]                 b_rid_ext, b_rid_m1, e_id_ext, e_id_m1;
   logic                          rid_ok, e_ok, sidx_ok, fifo_full;
   logic [MAW-1:0]                rid_idx, e_idx;
   logic [lfsa_pkg::ID_W-1:0]     e_id;
   logic [lfsa_pkg::WEIGHT_W-1:0] e_w;
   logic [LW-1:0]                 sidx_ext, sidx_m1;
   logic [FAW:0]                  tail_sum;
   logic [FAW-1:0]                tail, head_inc;

   always_comb begin
      pos_b = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            pos_b = SW'(g*8) + SW'(grp_idx_ff[g]) + SW'(1);
         end
      end
   end

   assign free_any  = |grp_any_ff;
   assign pos_m1    = pos_b - SW'(1);
   assign mpos_m1   = map_rd_ff - SW'(1);
   assign b_rid_ext = RW'(b_rid_ff);
   assign b_rid_m1  = b_rid_ext - RW'(1);
   assign rid_ok    = (b_rid_ext != '0) && (b_rid_ext <= RW'(REQUESTERS));
   assign rid_idx   = b_rid_m1[MAW-1:0];
   assign e_id      = fifo_rd_ff[FW-1:lfsa_pkg::WEIGHT_W];
   assign e_w       = fifo_rd_ff[lfsa_pkg::WEIGHT_W-1:0];
   assign e_id_ext  = RW'(e_id);
   assign e_id_m1   = e_id_ext - RW'(1);
   assign e_ok      = (e_id_ext != '0) && (e_id_ext <= RW'(REQUESTERS));
   assign e_idx     = e_id_m1[MAW-1:0];
   assign sidx_ext  = LW'(b_sidx_ff);
   assign sidx_m1   = sidx_ext - LW'(1);
   assign sidx_ok   = (sidx_ext != '0) && (sidx_ext <= LW'(SLOTS));
   assign fifo_full = count_ff >= CW'(WAIT_DEPTH);
   assign tail_sum  = {1'b0, head_ff} + {1'b0, count_ff[FAW-1:0]};
   assign tail      = (tail_sum >= (FAW+1)'(WAIT_DEPTH)) ?
                      FAW'(tail_sum - (FAW+1)'(WAIT_DEPTH)) : tail_sum[FAW-1:0];
   assign head_inc  = (head_ff == FAW'(WAIT_DEPTH - 1)) ? '0 : head_ff + FAW'(1);

   logic                          busy_set, busy_clr, busy_wipe;
   logic                          mapb_we;
   logic [SW-1:0]                 mapb_data;
   logic                          fifo_we, pend_set, rate_we, clr_tot, swp_go;
   logic [SIW-1:0]                rate_raddr;
   logic [lfsa_pkg::WEIGHT_W-1:0] chg_w;
   logic [lfsa_pkg::ID_W-1:0]     pl_req;
   logic [SW-1:0]                 pl_slot;
   logic                          queued;
   lfsa_pkg::status_type          st_b;

   always_comb begin
      busy_set   = 1'b0;
      busy_clr   = 1'b0;
      busy_wipe  = 1'b0;
      mapb_we    = 1'b0;
      mapb_data  = '0;
      fifo_we    = 1'b0;
      pend_set   = 1'b0;
      rate_we    = 1'b0;
      clr_tot    = 1'b0;
      swp_go     = 1'b0;
      rate_raddr = '0;
      chg_w      = '0;
      pl_req     = '0;
      pl_slot    = '0;
      queued     = 1'b0;
      st_b       = lfsa_pkg::ST_OK;
      head_in    = head_ff;
      count_in   = count_ff;
      case (b_op_ff)
         lfsa_pkg::OP_LOAD_RATE: begin
            rate_we = sidx_ok;
         end
         lfsa_pkg::OP_ARRIVE: begin
            if (rid_ok) begin
               if (free_any) begin
                  busy_set   = 1'b1;
                  mapb_we    = 1'b1;
                  mapb_data  = pos_b;
                  chg_w      = b_w_ff;
                  rate_raddr = pos_m1[SIW-1:0];
                  pl_req     = b_rid_ff;
                  pl_slot    = pos_b;
               end else if (fifo_full) begin
                  st_b = lfsa_pkg::ST_FULL;
               end else begin
                  fifo_we  = 1'b1;
                  count_in = count_ff + CW'(1);
                  queued   = 1'b1;
               end
            end
         end
         lfsa_pkg::OP_DEPART: begin
            if (!rid_ok || map_rd_ff == '0) begin
               st_b = lfsa_pkg::ST_NO_SLOT;
            end else begin
               mapb_we = 1'b1;
               if (count_ff == '0) begin
                  busy_clr = 1'b1;
               end else begin
                  head_in    = head_inc;
                  count_in   = count_ff - CW'(1);
                  pend_set   = e_ok;
                  chg_w      = e_w;
                  rate_raddr = mpos_m1[SIW-1:0];
                  pl_req     = e_id;
                  pl_slot    = map_rd_ff;
               end
            end
         end
         lfsa_pkg::OP_CLEAR: begin
            busy_wipe = 1'b1;
            head_in   = '0;
            count_in  = '0;
            clr_tot   = 1'b1;
            swp_go    = 1'b1;
         end
         default: begin
            st_b = lfsa_pkg::ST_OK;
         end
      endcase
   end

   logic b_fire;
   assign b_fire = adv && b_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= '0;
         head_ff  <= '0;
         count_ff <= '0;
      end else if (b_fire) begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (busy_wipe) begin
            busy_ff <= '0;
         end else if (busy_set) begin
            busy_ff[pos_m1[SIW-1:0]] <= 1'b1;
         end else if (busy_clr) begin
            busy_ff[mpos_m1[SIW-1:0]] <= 1'b0;
         end
      end
   end

   // second map write of a hand-over
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
      end else begin
         pend_vld_ff <= b_fire && pend_set;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         pend_addr_ff <= e_idx;
         pend_data_ff <= map_rd_ff;
      end
   end

   // clearing pass
   logic [SCW:0] swp_cnt_ext;
   logic         swp_map_hit, swp_rate_hit, swp_last;

   assign swp_cnt_ext  = (SCW+1)'(swp_cnt_ff);
   assign swp_map_hit  = swp_vld_ff && (swp_cnt_ext < (SCW+1)'(REQUESTERS));
   assign swp_rate_hit = swp_vld_ff && swp_rates_ff && (swp_cnt_ext < (SCW+1)'(SLOTS));
   assign swp_last     = swp_cnt_ff == SCW'(SWN - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         swp_vld_ff   <= 1'b1;
         swp_rates_ff <= 1'b1;
         swp_cnt_ff   <= '0;
      end else if (b_fire && swp_go) begin
         swp_vld_ff   <= 1'b1;
         swp_rates_ff <= 1'b0;
         swp_cnt_ff   <= '0;
      end else if (swp_vld_ff) begin
         swp_cnt_ff <= swp_cnt_ff + SCW'(1);
         if (swp_last) begin
            swp_vld_ff   <= 1'b0;
            swp_rates_ff <= 1'b0;
         end
      end
   end

   // map write port
   logic           map_we;
   logic [MAW-1:0] map_waddr;
   logic [SW-1:0]  map_wdata;

   always_comb begin
      map_we    = 1'b0;
      map_waddr = rid_idx;
      map_wdata = mapb_data;
      if (swp_map_hit) begin
         map_we    = 1'b1;
         map_waddr = swp_cnt_ff[MAW-1:0];
         map_wdata = '0;
      end else if (pend_vld_ff) begin
         map_we    = 1'b1;
         map_waddr = pend_addr_ff;
         map_wdata = pend_data_ff;
      end else if (b_fire && mapb_we) begin
         map_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire && fifo_we) begin
         fifo_mem[tail] <= {b_rid_ff, b_w_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (swp_rate_hit) begin
         rate_mem[swp_cnt_ff[SIW-1:0]] <= '0;
      end else if (b_fire && rate_we) begin
         rate_mem[sidx_m1[SIW-1:0]] <= b_rate_ff;
      end
   end

   // ---------------------------------------------------------------- stage C
   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         rate_rd_ff <= rate_mem[rate_raddr];
         c_w_ff     <= chg_w;
         c_clr_ff   <= clr_tot;
         c_req_ff   <= pl_req;
         c_slot_ff  <= lfsa_pkg::SLOT_W'(pl_slot);
         c_q_ff     <= queued;
         c_cnt_ff   <= lfsa_pkg::COUNT_W'(count_in);
         c_st_ff    <= st_b;
      end
   end

   // ---------------------------------------------------------------- stage D
   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && c_vld_ff) begin
         d_prod_ff <= lfsa_pkg::PROD_W'(c_w_ff) * lfsa_pkg::PROD_W'(rate_rd_ff);
         d_clr_ff  <= c_clr_ff;
         d_req_ff  <= c_req_ff;
         d_slot_ff <= c_slot_ff;
         d_q_ff    <= c_q_ff;
         d_cnt_ff  <= c_cnt_ff;
         d_st_ff   <= c_st_ff;
      end
   end

   // ---------------------------------------------------------------- total
   logic [TW:0] tot_sum;

   assign tot_sum  = {1'b0, total_ff} + (TW+1)'(d_prod_ff);
   assign total_in = d_clr_ff ? '0 :
                     (tot_sum[TW] ? lfsa_pkg::TOTAL_MAX : tot_sum[TW-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (adv && d_vld_ff) begin
         total_ff <= total_in;
      end
   end

   // ---------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && d_vld_ff) begin
         rsp_req_ff  <= d_req_ff;
         rsp_slot_ff <= d_slot_ff;
         rsp_q_ff    <= d_q_ff;
         rsp_cnt_ff  <= d_cnt_ff;
         rsp_tot_ff  <= total_in;
         rsp_st_ff   <= d_st_ff;
      end
   end

   assign rsp_valid            = rsp_vld_ff;
   assign rsp_placed_requester = rsp_req_ff;
   assign rsp_placed_slot      = rsp_slot_ff;
   assign rsp_was_queued       = rsp_q_ff;
   assign rsp_waiting_count    = rsp_cnt_ff;
   assign rsp_charge_total     = rsp_tot_ff;
   assign rsp_status           = rsp_st_ff;

   // ---------------------------------------------------------------- checks
   a_pend_excl: assert property (@(posedge clock) disable iff (reset)
      !(pend_vld_ff && b_vld_ff))
      else $error("map hand-over write overlaps a transaction in the update stage");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(WAIT_DEPTH))
      else $error("waiting count beyond FIFO depth");

   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      (b_fire && b_op_ff == lfsa_pkg::OP_CLEAR) |=> (swp_vld_ff && !b_vld_ff))
      else $error("clear-all did not start the map clearing pass");

   a_queue_no_place: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_q_ff) |-> (rsp_req_ff == '0 && rsp_slot_ff == '0))
      else $error("queued arrival also reports a placement");

endmodule

`default_nettype wire

FILE: tb/tb_lowest_free_slot_allocator_fifo_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lowest_free_slot_allocator_fifo_top
// Self-checking bench for the lowest free slot allocator. A directed table
// covers the corner cases. The FIFO is then filled with no active slots and
// drained through two slots. Mixed traffic runs under several active-slot
// settings, and a short arrive/depart run at full rate and weight repeats the
// largest charge. Responses are checked against the table or an allocator model.
// ----------------------------------------------------------------------------

module tb_lowest_free_slot_allocator_fifo_top;

   localparam int ID_W     = lfsa_pkg::ID_W;
   localparam int SLOT_W   = lfsa_pkg::SLOT_W;
   localparam int RATE_W   = lfsa_pkg::RATE_W;
   localparam int WEIGHT_W = lfsa_pkg::WEIGHT_W;
   localparam int COUNT_W  = lfsa_pkg::COUNT_W;
   localparam int TOTAL_W  = lfsa_pkg::TOTAL_W;
   localparam int ACTIVE_W = lfsa_pkg::ACTIVE_W;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = lfsa_pkg::TOTAL_MAX;

   localparam int NUM_SLOTS   = lfsa_pkg::SLOTS_DEF;
   localparam int NUM_REQ     = lfsa_pkg::REQUESTERS_DEF;
   localparam int FIFO_DEPTH  = lfsa_pkg::WAIT_DEPTH_DEF;
   localparam int PEAK_PAIRS  = 20;
   localparam int HOLD_CYCLES = 400;
   localparam int MIX_ITEMS   = 25;
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_LIMIT = 20000;

   typedef struct packed {
      lfsa_pkg::op_type    op;
      logic [SLOT_W-1:0]   slot;
      logic [RATE_W-1:0]   rate;
      logic [ID_W-1:0]     id;
      logic [WEIGHT_W-1:0] weight;
   } alloc_req_type;

   typedef struct packed {
      logic [ID_W-1:0]      placed_id;
      logic [SLOT_W-1:0]    placed_slot;
      logic                 queued;
      logic [COUNT_W-1:0]   waiting;
      logic [TOTAL_W-1:0]   total;
      lfsa_pkg::status_type status;
   } alloc_rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [WEIGHT_W-1:0] weight;
   } waiter_type;

   typedef struct {
      alloc_req_type req;
      bit            typed;
      alloc_rsp_type want;
   } script_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_opcode = '0;
   logic [SLOT_W-1:0]   req_slot_index = '0;
   logic [RATE_W-1:0]   req_rate_value = '0;
   logic [ID_W-1:0]     req_requester_id = '0;
   logic [WEIGHT_W-1:0] req_requester_weight = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [ID_W-1:0]     rsp_placed_requester;
   logic [SLOT_W-1:0]   rsp_placed_slot;
   logic                rsp_was_queued;
   logic [COUNT_W-1:0]  rsp_waiting_count;
   logic [TOTAL_W-1:0]  rsp_charge_total;
   logic [1:0]          rsp_status;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [ACTIVE_W-1:0] csr_active_slots = '0;

   lowest_free_slot_allocator_fifo_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_slot_index       (req_slot_index),
      .req_rate_value       (req_rate_value),
      .req_requester_id     (req_requester_id),
      .req_requester_weight (req_requester_weight),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_placed_requester (rsp_placed_requester),
      .rsp_placed_slot      (rsp_placed_slot),
      .rsp_was_queued       (rsp_was_queued),
      .rsp_waiting_count    (rsp_waiting_count),
      .rsp_charge_total     (rsp_charge_total),
      .rsp_status           (rsp_status),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_active_slots     (csr_active_slots)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // allocator model state
   logic [RATE_W-1:0]   rate_mem [1:NUM_SLOTS];
   bit                  busy_mem [1:NUM_SLOTS];
   logic [SLOT_W-1:0]   seat_of  [1:NUM_REQ];
   waiter_type          wait_line[$];
   logic [TOTAL_W-1:0]  total_acc;
   logic [ACTIVE_W-1:0] active_cfg;

   alloc_rsp_type pending_rsp[$];
   bit          gapless = 1'b0;
   bit          sink_open = 1'b0;
   int unsigned hold_len = 0;
   int unsigned burst_left = 0;
   int unsigned items_sent = 0;
   int unsigned checked = 0;
   int unsigned mismatches = 0;
   int unsigned n_handoff = 0;
   int unsigned n_queued = 0;
   int unsigned n_full = 0;
   int unsigned n_no_slot = 0;

   function automatic void model_clear();
      foreach (busy_mem[i]) busy_mem[i] = 1'b0;
      foreach (seat_of[i]) seat_of[i] = '0;
      wait_line.delete();
      total_acc = '0;
   endfunction

   function automatic void add_charge(input logic [WEIGHT_W-1:0] w, input int unsigned s);
      logic [TOTAL_W-1:0] amount;
      amount = TOTAL_W'(w) * TOTAL_W'(rate_mem[s]);
      if (amount > TOTAL_MAX - total_acc) total_acc = TOTAL_MAX;
      else total_acc = total_acc + amount;
   endfunction

   function automatic int unsigned first_free_slot();
      int unsigned lim;
      lim = (active_cfg > NUM_SLOTS) ? NUM_SLOTS : active_cfg;
      for (int unsigned s = 1; s <= lim; s++) begin
         if (!busy_mem[s]) return s;
      end
      return 0;
   endfunction

   function automatic alloc_rsp_type allocate_step(input alloc_req_type r);
      alloc_rsp_type o;
      int unsigned   s;
      bit            id_ok;
      waiter_type    head;
      o = '0;
      o.status = lfsa_pkg::ST_OK;
      id_ok = (r.id >= 1) && (r.id <= NUM_REQ);
      case (r.op)
         lfsa_pkg::OP_LOAD_RATE: begin
            if (r.slot >= 1 && r.slot <= NUM_SLOTS) rate_mem[r.slot] = r.rate;
         end
         lfsa_pkg::OP_ARRIVE: begin
            if (id_ok) begin
               s = first_free_slot();
               if (s != 0) begin
                  busy_mem[s] = 1'b1;
                  seat_of[r.id] = SLOT_W'(s);
                  add_charge(r.weight, s);
                  o.placed_id = r.id;
                  o.placed_slot = SLOT_W'(s);
               end else if (wait_line.size() >= FIFO_DEPTH) begin
                  o.status = lfsa_pkg::ST_FULL;
               end else begin
                  wait_line.push_back(waiter_type'{r.id, r.weight});
                  o.queued = 1'b1;
               end
            end
         end
         lfsa_pkg::OP_DEPART: begin
            s = 0;
            if (id_ok) s = seat_of[r.id];
            if (s == 0) begin
               o.status = lfsa_pkg::ST_NO_SLOT;
            end else begin
               seat_of[r.id] = '0;
               if (wait_line.size() == 0) begin
                  busy_mem[s] = 1'b0;
               end else begin
                  head = wait_line.pop_front();
                  seat_of[head.id] = SLOT_W'(s);
                  add_charge(head.weight, s);
                  o.placed_id = head.id;
                  o.placed_slot = SLOT_W'(s);
               end
            end
         end
         default: model_clear();
      endcase
      o.waiting = COUNT_W'(wait_line.size());
      o.total = total_acc;
      return o;
   endfunction

   function automatic alloc_rsp_type outcome(input int id, input int slot,
                                             input logic [TOTAL_W-1:0] tot,
                                             input lfsa_pkg::status_type st);
      alloc_rsp_type o;
      o = '0;
      o.placed_id = ID_W'(id);
      o.placed_slot = SLOT_W'(slot);
      o.total = tot;
      o.status = st;
      return o;
   endfunction

   function automatic alloc_req_type noise_item();
      alloc_req_type r;
      r.op = lfsa_pkg::op_type'($urandom_range(0, 3));
      r.slot = SLOT_W'($urandom);
      r.rate = RATE_W'($urandom);
      r.id = ID_W'($urandom);
      r.weight = WEIGHT_W'($urandom);
      return r;
   endfunction

   function automatic logic [ID_W-1:0] some_id();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return ID_W'($urandom_range(1, 48));
      if (r < 90) return ID_W'($urandom_range(1, NUM_REQ));
      if (r < 95) return r[0] ? ID_W'(1) : ID_W'(NUM_REQ);
      if (r < 97) return '0;
      return ID_W'($urandom_range(NUM_REQ + 1, 2**ID_W - 1));
   endfunction

   function automatic logic [ID_W-1:0] some_holder();
      logic [ID_W-1:0] found[$];
      for (int i = 1; i <= NUM_REQ; i++) begin
         if (seat_of[i] != 0) found.push_back(ID_W'(i));
      end
      if (found.size() == 0) return '0;
      return found[$urandom_range(0, found.size() - 1)];
   endfunction

   function automatic alloc_req_type mixed_item();
      alloc_req_type r;
      int unsigned   pick;
      r = noise_item();
      pick = $urandom_range(0, 99);
      if (pick < 36) begin
         r.op = lfsa_pkg::OP_ARRIVE;
         r.id = some_id();
         if (pick < 6) r.weight = '1;
      end else if (pick < 66) begin
         r.op = lfsa_pkg::OP_DEPART;
         r.id = some_holder();
         if (r.id == 0 || pick >= 60) r.id = some_id();
      end else if (pick < 88) begin
         r.op = lfsa_pkg::OP_LOAD_RATE;
         r.slot = (pick < 80) ? SLOT_W'($urandom_range(1, 10))
                              : SLOT_W'($urandom_range(0, 255));
         if (pick < 70) r.rate = '1;
      end else if (pick < 91) begin
         r.op = lfsa_pkg::OP_CLEAR;
      end
      return r;
   endfunction

   function automatic void note_bad(input string what, input alloc_rsp_type want,
                                    input alloc_rsp_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t %s: exp id=%0d slot=%0d q=%0d wait=%0d total=%h st=%0d",
                  $time, what, want.placed_id, want.placed_slot, want.queued,
                  want.waiting, want.total, want.status);
         $display("      got id=%0d slot=%0d q=%0d wait=%0d total=%h st=%0d",
                  got.placed_id, got.placed_slot, got.queued, got.waiting,
                  got.total, got.status);
      end
   endfunction

   task automatic send(input alloc_req_type r, input bit typed = 1'b0,
                       input alloc_rsp_type want = '0);
      alloc_rsp_type pred;
      int unsigned   gap;
      if (!gapless) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            burst_left = $urandom_range(1, 16);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left--;
      end
      req_valid <= 1'b1;
      req_opcode <= r.op;
      req_slot_index <= r.slot;
      req_rate_value <= r.rate;
      req_requester_id <= r.id;
      req_requester_weight <= r.weight;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = allocate_step(r);
      pending_rsp.push_back(typed ? want : pred);
      items_sent++;
      if (r.op == lfsa_pkg::OP_DEPART && pred.placed_id != 0) n_handoff++;
      if (pred.queued) n_queued++;
      if (pred.status == lfsa_pkg::ST_FULL) n_full++;
      if (pred.status == lfsa_pkg::ST_NO_SLOT) n_no_slot++;
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic set_active(input logic [ACTIVE_W-1:0] v);
      csr_valid <= 1'b1;
      csr_active_slots <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      active_cfg = v;
   endtask

   // response checker
   always @(posedge clock) begin
      alloc_rsp_type got;
      alloc_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.placed_id = rsp_placed_requester;
         got.placed_slot = rsp_placed_slot;
         got.queued = rsp_was_queued;
         got.waiting = rsp_waiting_count;
         got.total = rsp_charge_total;
         got.status = lfsa_pkg::status_type'(rsp_status);
         if (pending_rsp.size() == 0) begin
            note_bad("unexpected response", '0, got);
         end else begin
            want = pending_rsp.pop_front();
            checked++;
            if (got.placed_id !== want.placed_id || got.placed_slot !== want.placed_slot ||
                got.queued !== want.queued || got.waiting !== want.waiting ||
                got.total !== want.total || got.status !== want.status)
               note_bad("response mismatch", want, got);
         end
      end
   end

   // receiver: own stall pattern, long hold-off on request
   initial begin : rsp_side
      bit          level;
      int unsigned run;
      level = 1'b1;
      run = 0;
      @(posedge clock);
      forever begin
         if (hold_len != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
         end else begin
            if (sink_open) begin
               rsp_ready <= 1'b1;
            end else begin
               if (run == 0) begin
                  level = !level;
                  run = level ? $urandom_range(1, 24) : $urandom_range(1, 6);
               end
               run--;
               rsp_ready <= level;
            end
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      #(18_000_000);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      script_row_type      script[$];
      alloc_req_type       r;
      alloc_req_type       arr;
      alloc_req_type       dep;
      logic [ID_W-1:0]     holder;
      logic [ACTIVE_W-1:0] mix_cfg [5];
      int unsigned         extra;
      int unsigned         waited;

      active_cfg = lfsa_pkg::ACTIVE_RESET;
      foreach (rate_mem[i]) rate_mem[i] = '0;
      model_clear();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, active slots at reset value
      script.push_back('{'{lfsa_pkg::OP_DEPART, 8'd0, 16'd0, 11'd5, 16'd0}, 1'b1,
                         outcome(0, 0, 0, lfsa_pkg::ST_NO_SLOT)});
      script.push_back('{'{lfsa_pkg::OP_DEPART, 8'd0, 16'd0, 11'd0, 16'd0}, 1'b1,
                         outcome(0, 0, 0, lfsa_pkg::ST_NO_SLOT)});
      script.push_back('{'{lfsa_pkg::OP_DEPART, 8'd255, 16'hFFFF, 11'd2047, 16'hFFFF},
                         1'b1, outcome(0, 0, 0, lfsa_pkg::ST_NO_SLOT)});
      script.push_back('{'{lfsa_pkg::OP_ARRIVE, 8'd0, 16'd0, 11'd0, 16'hFFFF}, 1'b1,
                         outcome(0, 0, 0, lfsa_pkg::ST_OK)});
      script.push_back('{'{lfsa_pkg::OP_ARRIVE, 8'd0, 16'd0, 11'd1025, 16'hFFFF}, 1'b1,
                         outcome(0, 0, 0, lfsa_pkg::ST_OK)});
      script.push_back('{'{lfsa_pkg::OP_ARRIVE, 8'd0, 16'd0, 11'd2047, 16'hFFFF}, 1'b1,
                         outcome(0, 0, 0, lfsa_pkg::ST_OK)});
      script.push_back('{'{lfsa_pkg::OP_LOAD_RATE, 8'd0, 16'hFFFF, 11'd0, 16'd0}, 1'b1,
                         outcome(0, 0, 0, lfsa_pkg::ST_OK)});
      script.push_back('{'{lfsa_pkg::OP_LOAD_RATE, 8'd129, 16'hFFFF, 11'd0, 16'd0}, 1'b1,
                         outcome(0, 0, 0, lfsa_pkg::ST_OK)});
      script.push_back('{'{lfsa_pkg::OP_LOAD_RATE, 8'd255, 16'hFFFF, 11'd0, 16'd0}, 1'b1,
                         outcome(0, 0, 0, lfsa_pkg::ST_OK)});
      script.push_back('{'{lfsa_pkg::OP_ARRIVE, 8'd0, 16'd0, 11'd1, 16'hFFFF}, 1'b1,
                         outcome(1, 1, 0, lfsa_pkg::ST_OK)});
      script.push_back('{'{lfsa_pkg::OP_LOAD_RATE, 8'd1, 16'hFFFF, 11'd0, 16'd0}, 1'b1,
                         outcome(0, 0, 0, lfsa_pkg::ST_OK)});
      script.push_back('{'{lfsa_pkg::OP_LOAD_RATE, 8'd128, 16'hA5A5, 11'd0, 16'd0}, 1'b1,
                         outcome(0, 0, 0, lfsa_pkg::ST_OK)});
      script.push_back('{'{lfsa_pkg::OP_ARRIVE, 8'd0, 16'd0, 11'd1, 16'hFFFF}, 1'b1,
                         outcome(1, 2, 0, lfsa_pkg::ST_OK)});
      script.push_back('{'{lfsa_pkg::OP_DEPART, 8'd0, 16'd0, 11'd1, 16'd0}, 1'b1,
                         outcome(0, 0, 0, lfsa_pkg::ST_OK)});
      script.push_back('{'{lfsa_pkg::OP_DEPART, 8'd0, 16'd0, 11'd1, 16'd0}, 1'b1,
                         outcome(0, 0, 0, lfsa_pkg::ST_NO_SLOT)});
      script.push_back('{'{lfsa_pkg::OP_ARRIVE, 8'd0, 16'd0, 11'd1024, 16'hFFFF}, 1'b1,
                         outcome(1024, 2, 0, lfsa_pkg::ST_OK)});
      script.push_back('{'{lfsa_pkg::OP_LOAD_RATE, 8'd3, 16'h5A5A, 11'd0, 16'd0}, 1'b0, '0});
      script.push_back('{'{lfsa_pkg::OP_ARRIVE, 8'd0, 16'd0, 11'd682, 16'h5555}, 1'b0, '0});
      script.push_back('{'{lfsa_pkg::OP_DEPART, 8'd0, 16'd0, 11'd682, 16'd0}, 1'b0, '0});
      script.push_back('{'{lfsa_pkg::OP_CLEAR, 8'd255, 16'hFFFF, 11'd2047, 16'hFFFF}, 1'b1,
                         outcome(0, 0, 0, lfsa_pkg::ST_OK)});
      script.push_back('{'{lfsa_pkg::OP_ARRIVE, 8'd0, 16'd0, 11'd7, 16'hFFFF}, 1'b1,
                         outcome(7, 1, 48'hFFFE0001, lfsa_pkg::ST_OK)});
      script.push_back('{'{lfsa_pkg::OP_ARRIVE, 8'd0, 16'd0, 11'd9, 16'd1}, 1'b0, '0});
      script.push_back('{'{lfsa_pkg::OP_DEPART, 8'd0, 16'd0, 11'd7, 16'd0}, 1'b0, '0});
      script.push_back('{'{lfsa_pkg::OP_CLEAR, 8'd0, 16'd0, 11'd0, 16'd0}, 1'b1,
                         outcome(0, 0, 0, lfsa_pkg::ST_OK)});
      foreach (script[i]) send(script[i].req, script[i].typed, script[i].want);
      drain_all();

      // no active slots: every arrival queues until the FIFO is full; receiver held off
      set_active('0);
      gapless = 1'b1;
      hold_len = HOLD_CYCLES;
      for (int i = 0; i < FIFO_DEPTH + 9; i++) begin
         r = noise_item();
         if ($urandom_range(0, 39) == 0) begin
            r.op = lfsa_pkg::OP_DEPART;
            r.id = some_id();
         end else begin
            r.op = lfsa_pkg::OP_ARRIVE;
            r.id = ID_W'($urandom_range(1, NUM_REQ));
            if ($urandom_range(0, 7) == 0) r.weight = '1;
         end
         send(r);
      end
      gapless = 1'b0;
      drain_all();

      // two slots: departures hand slots down the FIFO until it empties
      set_active(8'd2);
      extra = 0;
      for (int i = 0; i < 360 && extra < 10; i++) begin
         r = noise_item();
         holder = some_holder();
         if (holder == 0 || $urandom_range(0, 99) < 8) begin
            r.op = lfsa_pkg::OP_ARRIVE;
            r.id = ID_W'($urandom_range(1, NUM_REQ));
         end else begin
            r.op = lfsa_pkg::OP_DEPART;
            r.id = holder;
         end
         send(r);
         if (wait_line.size() == 0) extra++;
      end
      drain_all();

      // mixed traffic over several settings
      mix_cfg = '{8'd255, 8'd3, 8'd1, 8'd0, 8'd128};
      mix_cfg[3] = ACTIVE_W'($urandom_range(4, 127));
      foreach (mix_cfg[k]) begin
         set_active(mix_cfg[k]);
         for (int i = 0; i < MIX_ITEMS; i++) begin
            send(mixed_item());
            if ($urandom_range(0, 19) == 0) drain_all();
         end
         drain_all();
      end

      // one slot at full rate and weight: the largest charge, back to back
      set_active(8'd1);
      gapless = 1'b1;
      sink_open = 1'b1;
      arr = '{lfsa_pkg::OP_ARRIVE, 8'd0, 16'd0, 11'd1, 16'hFFFF};
      dep = '{lfsa_pkg::OP_DEPART, 8'd0, 16'd0, 11'd1, 16'd0};
      send('{lfsa_pkg::OP_CLEAR, 8'd0, 16'd0, 11'd0, 16'd0});
      send('{lfsa_pkg::OP_LOAD_RATE, 8'd1, 16'hFFFF, 11'd0, 16'd0});
      for (int i = 0; i < PEAK_PAIRS; i++) begin
         send(arr);
         send(dep);
      end
      send(arr);
      send('{lfsa_pkg::OP_ARRIVE, 8'd0, 16'd0, 11'd2, 16'hFFFF});
      send(dep);
      send('{lfsa_pkg::OP_DEPART, 8'd0, 16'd0, 11'd2, 16'd0});
      send('{lfsa_pkg::OP_CLEAR, 8'd0, 16'd0, 11'd0, 16'd0});
      gapless = 1'b0;
      sink_open = 1'b0;

      req_valid <= 1'b0;
      waited = 0;
      while (pending_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (16) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         mismatches++;
         $display("%0d responses never arrived", pending_rsp.size());
      end

      $display("Sent %0d transactions, checked %0d responses, %0d failures",
               items_sent, checked, mismatches);
      $display("Hand-overs %0d, queued %0d, FIFO-full drops %0d, no-slot departures %0d",
               n_handoff, n_queued, n_full, n_no_slot);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/lfsa_pkg.sv
rtl/core/lowest_free_slot_allocator_fifo_top.sv
tb/tb_lowest_free_slot_allocator_fifo_top.sv
